### rtl/gqi_pkg.sv
`default_nettype none
package gqi_pkg;

  localparam int unsigned OpW   = 36;
  localparam int unsigned ProdW = 2 * OpW;

  typedef logic [5:0] step_t;
  typedef logic signed [OpW-1:0] op_t;
  typedef logic signed [ProdW-1:0] prod_t;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_SPT   = 2'd0;
  localparam logic [1:0] CFG_SCALE = 2'd1;
  localparam logic [1:0] CFG_GAIN  = 2'd2;

  localparam logic [31:0] SPT_RST   = 32'd281474977;
  localparam logic [31:0] SCALE_RST = 32'd4570811;
  localparam logic [15:0] GAIN_RST  = 16'd3277;
  localparam logic signed [31:0] Q_ONE = 32'sd1073741824;

  // Microcode steps, one multiply each.
  localparam step_t ST_HP  = 6'd0;
  localparam step_t ST_RX  = 6'd1;
  localparam step_t ST_RY  = 6'd2;
  localparam step_t ST_RZ  = 6'd3;
  localparam step_t ST_PY0 = 6'd4;
  localparam step_t ST_PY1 = 6'd5;
  localparam step_t ST_PZ0 = 6'd6;
  localparam step_t ST_PZ1 = 6'd7;
  localparam step_t ST_DY  = 6'd8;
  localparam step_t ST_DZ  = 6'd9;
  localparam step_t ST_AX  = 6'd10;
  localparam step_t ST_AY  = 6'd11;
  localparam step_t ST_AZ  = 6'd12;
  localparam step_t ST_W0  = 6'd13;
  localparam step_t ST_W1  = 6'd14;
  localparam step_t ST_W2  = 6'd15;
  localparam step_t ST_X0  = 6'd16;
  localparam step_t ST_X1  = 6'd17;
  localparam step_t ST_X2  = 6'd18;
  localparam step_t ST_Y0  = 6'd19;
  localparam step_t ST_Y1  = 6'd20;
  localparam step_t ST_Y2  = 6'd21;
  localparam step_t ST_Z0  = 6'd22;
  localparam step_t ST_Z1  = 6'd23;
  localparam step_t ST_Z2  = 6'd24;
  localparam step_t ST_N0  = 6'd25;
  localparam step_t ST_N1  = 6'd26;
  localparam step_t ST_N2  = 6'd27;
  localparam step_t ST_N3  = 6'd28;
  localparam step_t ST_T0  = 6'd29;
  localparam step_t ST_U0  = 6'd30;
  localparam step_t ST_R0  = 6'd31;
  localparam step_t ST_T1  = 6'd32;
  localparam step_t ST_U1  = 6'd33;
  localparam step_t ST_R1  = 6'd34;
  localparam step_t ST_QW  = 6'd35;
  localparam step_t ST_QX  = 6'd36;
  localparam step_t ST_QY  = 6'd37;
  localparam step_t ST_QZ  = 6'd38;
  localparam step_t STEP_LAST = ST_QZ;

  typedef struct packed {
    logic  load;
    logic  ident;
    logic  mul;
    logic  wb;
    logic  out_load;
    step_t step;
  } dp_cmd_t;

  function automatic logic signed [31:0] sat32(input prod_t v);
    logic signed [31:0] res;
    if (v > prod_t'(32'sh7FFF_FFFF)) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -prod_t'(32'sh4000_0000) * 2) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/gqi_ctrl.sv
`default_nettype none
module gqi_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_cmd,
  output logic                 in_ready,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output gqi_pkg::dp_cmd_t     cmd
);
  import gqi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  step_t      step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, emit;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  // The finished quaternion moves to the output register once it is free.
  assign emit      = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          step_nxt  = ST_HP;
          state_nxt = in_cmd ? S_DONE : S_MUL;
        end
      end
      S_MUL: state_nxt = S_WB;
      S_WB: begin
        if (step_r == STEP_LAST) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt  = step_r + 6'd1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_HP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.ident    = accept && in_cmd;
    cmd.mul      = (state_r == S_MUL);
    cmd.wb       = (state_r == S_WB);
    cmd.out_load = emit;
    cmd.step     = step_r;
  end

endmodule
`default_nettype wire

### rtl/gqi_dpath.sv
`default_nettype none
module gqi_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gqi_pkg::dp_cmd_t  cmd,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic [31:0]       in_ts,
  input  wire logic [15:0]       in_gx,
  input  wire logic [15:0]       in_gy,
  input  wire logic [15:0]       in_gz,
  output logic [127:0]           out_data
);
  import gqi_pkg::*;

  logic [31:0] spt_r, scale_r;
  logic [15:0] gain_r;
  logic [31:0] last_ts_r, ts_r;
  logic signed [15:0] gx_r, gy_r, gz_r;
  logic signed [31:0] qw_r, qx_r, qy_r, qz_r;
  logic [31:0] hp_r;
  op_t rx_r, ry_r, rz_r, py_r, pz_r;
  logic signed [31:0] ax_r, ay_r, az_r;
  op_t nw_r, nx_r, ny_r, nz_r;
  logic [OpW-1:0] n2_r;
  logic [32:0] t_r;
  logic signed [31:0] f_r, r_r;
  prod_t p_r;
  op_t opa, opb;
  logic [127:0] out_r;

  logic [31:0] dt;
  logic [31:0] n2_sat;
  logic signed [31:0] snw, snx, sny, snz, srx, sry, srz;
  prod_t hp_wide;
  op_t fdiff;

  assign dt      = ts_r - last_ts_r;
  assign n2_sat  = (n2_r > OpW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : n2_r[31:0];
  assign snw     = sat32(ProdW'(nw_r));
  assign snx     = sat32(ProdW'(nx_r));
  assign sny     = sat32(ProdW'(ny_r));
  assign snz     = sat32(ProdW'(nz_r));
  assign srx     = sat32(ProdW'(rx_r));
  assign sry     = sat32(ProdW'(ry_r));
  assign srz     = sat32(ProdW'(rz_r));
  assign hp_wide = p_r >>> 17;
  assign fdiff   = op_t'(36'sd1610612736) - $signed({3'b000, p_r[63:31]});
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= SPT_RST;
      scale_r <= SCALE_RST;
      gain_r  <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SPT:   spt_r   <= cfg_wdata;
        CFG_SCALE: scale_r <= cfg_wdata;
        CFG_GAIN:  gain_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Operand select for the shared multiplier.
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.step)
      ST_HP:  begin opa = {4'b0, dt};        opb = {4'b0, spt_r};   end
      ST_RX:  begin opa = OpW'(gy_r);        opb = {4'b0, scale_r}; end
      ST_RY:  begin opa = OpW'(gx_r);        opb = {4'b0, scale_r}; end
      ST_RZ:  begin opa = -OpW'(gz_r);       opb = {4'b0, scale_r}; end
      ST_PY0: begin opa = OpW'(qx_r);        opb = OpW'(qz_r);      end
      ST_PY1: begin opa = OpW'(qw_r);        opb = OpW'(qy_r);      end
      ST_PZ0: begin opa = OpW'(qx_r);        opb = OpW'(qy_r);      end
      ST_PZ1: begin opa = OpW'(qw_r);        opb = OpW'(qz_r);      end
      ST_DY:  begin opa = py_r;              opb = {20'b0, gain_r}; end
      ST_DZ:  begin opa = pz_r;              opb = {20'b0, gain_r}; end
      ST_AX:  begin opa = OpW'(srx);         opb = {4'b0, hp_r};    end
      ST_AY:  begin opa = OpW'(sry);         opb = {4'b0, hp_r};    end
      ST_AZ:  begin opa = OpW'(srz);         opb = {4'b0, hp_r};    end
      ST_W0:  begin opa = OpW'(qx_r);        opb = OpW'(ax_r);      end
      ST_W1:  begin opa = OpW'(qy_r);        opb = OpW'(ay_r);      end
      ST_W2:  begin opa = OpW'(qz_r);        opb = OpW'(az_r);      end
      ST_X0:  begin opa = OpW'(qw_r);        opb = OpW'(ax_r);      end
      ST_X1:  begin opa = OpW'(qy_r);        opb = OpW'(az_r);      end
      ST_X2:  begin opa = OpW'(qz_r);        opb = OpW'(ay_r);      end
      ST_Y0:  begin opa = OpW'(qw_r);        opb = OpW'(ay_r);      end
      ST_Y1:  begin opa = OpW'(qx_r);        opb = OpW'(az_r);      end
      ST_Y2:  begin opa = OpW'(qz_r);        opb = OpW'(ax_r);      end
      ST_Z0:  begin opa = OpW'(qw_r);        opb = OpW'(az_r);      end
      ST_Z1:  begin opa = OpW'(qx_r);        opb = OpW'(ay_r);      end
      ST_Z2:  begin opa = OpW'(qy_r);        opb = OpW'(ax_r);      end
      ST_N0:  begin opa = OpW'(snw);         opb = OpW'(snw);       end
      ST_N1:  begin opa = OpW'(snx);         opb = OpW'(snx);       end
      ST_N2:  begin opa = OpW'(sny);         opb = OpW'(sny);       end
      ST_N3:  begin opa = OpW'(snz);         opb = OpW'(snz);       end
      ST_T0, ST_T1: begin opa = OpW'(r_r);   opb = OpW'(r_r);       end
      ST_U0, ST_U1: begin opa = {4'b0, n2_sat}; opb = {3'b0, t_r};  end
      ST_R0, ST_R1: begin opa = OpW'(r_r);   opb = OpW'(f_r);       end
      ST_QW:  begin opa = OpW'(snw);         opb = OpW'(r_r);       end
      ST_QX:  begin opa = OpW'(snx);         opb = OpW'(r_r);       end
      ST_QY:  begin opa = OpW'(sny);         opb = OpW'(r_r);       end
      ST_QZ:  begin opa = OpW'(snz);         opb = OpW'(r_r);       end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_r <= opa * opb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r      <= Q_ONE;
      qx_r      <= '0;
      qy_r      <= '0;
      qz_r      <= '0;
      last_ts_r <= '0;
    end else if (cmd.ident) begin
      qw_r <= Q_ONE;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else if (cmd.wb) begin
      case (cmd.step)
        ST_HP: last_ts_r <= ts_r;
        ST_QW: qw_r <= sat32(p_r >>> 30);
        ST_QX: qx_r <= sat32(p_r >>> 30);
        ST_QY: qy_r <= sat32(p_r >>> 30);
        ST_QZ: qz_r <= sat32(p_r >>> 30);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ts_r <= in_ts;
      gx_r <= in_gx;
      gy_r <= in_gy;
      gz_r <= in_gz;
    end
    if (cmd.out_load) begin
      out_r <= {qz_r, qy_r, qx_r, qw_r};
    end
    if (cmd.wb) begin
      case (cmd.step)
        ST_HP: begin
          hp_r <= (hp_wide > ProdW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : hp_wide[31:0];
          nw_r <= OpW'(qw_r);
          nx_r <= OpW'(qx_r);
          ny_r <= OpW'(qy_r);
          nz_r <= OpW'(qz_r);
          r_r  <= Q_ONE;
        end
        ST_RX:  rx_r <= OpW'(p_r >>> 16);
        ST_RY:  ry_r <= OpW'(p_r >>> 16);
        ST_RZ:  rz_r <= OpW'(p_r >>> 16);
        ST_PY0: py_r <= OpW'(p_r >>> 30);
        ST_PY1: py_r <= py_r + OpW'(p_r >>> 30);
        ST_PZ0: pz_r <= OpW'(p_r >>> 30);
        ST_PZ1: pz_r <= pz_r - OpW'(p_r >>> 30);
        ST_DY:  ry_r <= ry_r - OpW'(p_r >>> 29);
        ST_DZ:  rz_r <= rz_r + OpW'(p_r >>> 29);
        ST_AX:  ax_r <= sat32(p_r >>> 18);
        ST_AY:  ay_r <= sat32(p_r >>> 18);
        ST_AZ:  az_r <= sat32(p_r >>> 18);
        ST_W0, ST_W1, ST_W2: nw_r <= nw_r - OpW'(p_r >>> 30);
        ST_X0, ST_X1:        nx_r <= nx_r + OpW'(p_r >>> 30);
        ST_X2:               nx_r <= nx_r - OpW'(p_r >>> 30);
        ST_Y0, ST_Y2:        ny_r <= ny_r + OpW'(p_r >>> 30);
        ST_Y1:               ny_r <= ny_r - OpW'(p_r >>> 30);
        ST_Z0, ST_Z1:        nz_r <= nz_r + OpW'(p_r >>> 30);
        ST_Z2:               nz_r <= nz_r - OpW'(p_r >>> 30);
        ST_N0:  n2_r <= OpW'(p_r >> 30);
        ST_N1, ST_N2, ST_N3: n2_r <= n2_r + OpW'(p_r >> 30);
        ST_T0, ST_T1: t_r <= p_r[62:30];
        // Unsigned product taken modulo 2^64 before the shift.
        ST_U0, ST_U1: f_r <= sat32(ProdW'(fdiff));
        ST_R0, ST_R1: r_r <= sat32(p_r >>> 30);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/gyro_quaternion_integrator.sv
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  tuser: cmd; tdata: ts, gyro x, y, z
// out_     master     out_tvalid/out_tready tdata: quat w, x, y, z
// cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An integrate command runs 39 multiplies on one shared 36x36 multiplier,
// each in a multiply state followed by a write-back state.
// A reset-orientation command skips the multiplies. One item is in work at a time;
// a new item is taken while the previous result waits in the output register.
// Synchronous active-low reset restores identity, timestamp zero and config.
`default_nettype none
module gyro_quaternion_integrator (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [79:0]  in_tdata,   // timestamp_ticks, gyro_x, gyro_y, gyro_z
  input  wire logic         in_tuser,   // cmd
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // quat_w, quat_x, quat_y, quat_z
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import gqi_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  gqi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_cmd    (in_tuser),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  gqi_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_ts     (in_tdata[31:0]),
    .in_gx     (in_tdata[47:32]),
    .in_gy     (in_tdata[63:48]),
    .in_gz     (in_tdata[79:64]),
    .out_data  (out_tdata)
  );

endmodule
`default_nettype wire

### rtl/gqi_checker.sv
`default_nettype none
module gqi_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic         cfg_ready
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // After an input transfer the block is not ready in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind gyro_quaternion_integrator gqi_checker u_gqi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
`default_nettype wire
